>>> sv/ber_tag_length_header_parser_top_defines.svh
// assertion macros used by the ber tag-length header parser port checker
// no dependencies; included by the checker file
`ifndef BER_TAG_LENGTH_HEADER_PARSER_TOP_DEFINES_SVH
`define BER_TAG_LENGTH_HEADER_PARSER_TOP_DEFINES_SVH

// concurrent assertion, disabled while reset is asserted
`define BTLHP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion that also holds during reset
`define BTLHP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/btlhp_pkg.sv
// shared types and constants of the ber tag-length header parser
// no dependencies
`default_nettype none

package btlhp_pkg;

  // default limit on long-form length octets
  localparam int unsigned MaxLenOctetsDef = 4;

  // tag number that announces one extension byte
  localparam logic [4:0] TagNumExt = 5'h1F;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PhIdent    = 4'b0001,
    PhExt      = 4'b0010,
    PhLenFirst = 4'b0100,
    PhLenMore  = 4'b1000
  } phase_e;

  // result status codes
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StIndef   = 2'd1,
    StTooMany = 2'd2,
    StTrunc   = 2'd3
  } status_e;

  // parser state apart from the octet countdown
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  tag;
    logic [6:0]  ext;
    logic [31:0] acc;
    logic [2:0]  oct_cnt;
    logic [1:0]  tag_cnt;
  } parse_state_t;

  // one header result
  typedef struct packed {
    status_e     status;
    logic [7:0]  tag;
    logic [6:0]  ext;
    logic [1:0]  tag_cnt;
    logic [31:0] len;
    logic [2:0]  oct_cnt;
  } result_t;

endpackage

`default_nettype wire

>>> sv/btlhp_step.sv
// next-state and result logic for one stream byte
// depends on btlhp_pkg
`default_nettype none

module btlhp_step import btlhp_pkg::*; #(
  parameter int unsigned MAX_LEN_OCTETS = MaxLenOctetsDef,
  parameter int unsigned RemW           = $clog2(MAX_LEN_OCTETS + 1)
) (
  input  parse_state_t    st_q_i,
  input  logic [RemW-1:0] rem_q_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_data_i,
  output parse_state_t    st_d_o,
  output logic [RemW-1:0] rem_d_o,
  output logic            emit_o,
  output result_t         res_o
);

  localparam logic [6:0] MaxN = 7'(MAX_LEN_OCTETS);

  logic [6:0]      n;
  logic [RemW-1:0] rem_dec;
  logic [31:0]     acc_shift;
  status_e         status;
  logic [31:0]     len;

  assign n         = data_byte_i[6:0];
  assign rem_dec   = rem_q_i - RemW'(1);
  assign acc_shift = {st_q_i.acc[23:0], data_byte_i};

  // parse one byte
  always_comb begin
    st_d_o  = st_q_i;
    rem_d_o = rem_q_i;
    emit_o  = 1'b0;
    status  = StOk;
    len     = '0;
    case (st_q_i.phase)
      PhIdent: begin
        st_d_o.tag     = data_byte_i;
        st_d_o.ext     = '0;
        st_d_o.tag_cnt = 2'd1;
        st_d_o.oct_cnt = '0;
        st_d_o.acc     = '0;
        rem_d_o        = '0;
        st_d_o.phase   = (data_byte_i[4:0] == TagNumExt) ? PhExt : PhLenFirst;
      end
      PhExt: begin
        st_d_o.ext     = data_byte_i[6:0];
        st_d_o.tag_cnt = 2'd2;
        st_d_o.phase   = PhLenFirst;
      end
      PhLenFirst: begin
        st_d_o.oct_cnt = 3'd1;
        if (!data_byte_i[7]) begin
          emit_o = 1'b1;
          len    = {24'd0, data_byte_i};
        end else if (n == 7'd0) begin
          emit_o = 1'b1;
          status = StIndef;
        end else if (n > MaxN) begin
          emit_o = 1'b1;
          status = StTooMany;
        end else begin
          st_d_o.acc   = '0;
          rem_d_o      = n[RemW-1:0];
          st_d_o.phase = PhLenMore;
        end
      end
      PhLenMore: begin
        st_d_o.acc     = acc_shift;
        st_d_o.oct_cnt = st_q_i.oct_cnt + 3'd1;
        // countdown is always nonzero here; guard anyway
        if (rem_q_i != '0) rem_d_o = rem_dec;
        if (rem_q_i == '0 || rem_dec == '0) begin
          emit_o = 1'b1;
          len    = acc_shift;
        end
      end
      default: begin
        st_d_o.phase = PhIdent;
      end
    endcase

    // early end of data on a byte that did not close the header
    if (!emit_o && end_of_data_i) begin
      emit_o = 1'b1;
      status = StTrunc;
      len    = '0;
    end

    if (emit_o) st_d_o.phase = PhIdent;
  end

  // result tag and octet-count fields come from the updated state
  always_comb begin
    res_o.status  = status;
    res_o.tag     = st_d_o.tag;
    res_o.ext     = st_d_o.ext;
    res_o.tag_cnt = st_d_o.tag_cnt;
    res_o.len     = len;
    res_o.oct_cnt = st_d_o.oct_cnt;
  end

endmodule

`default_nettype wire

>>> sv/ber_tag_length_header_parser_top.sv
// top level of the ber tag-length header parser
// depends on btlhp_pkg and btlhp_step
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid_i, in_ready_o | data_byte_i, end_of_data_i
//  out     | out_valid_o, out_ready_i | status_o, tag_*_o, length_value_o, ...
//
// one byte is taken per cycle unless a held result blocks it; the header state and
// the result register update at the same edge, so a result shows in the cycle
// after its last byte. a held result blocks input only while out_ready_i is low.
// reset returns the parser to expecting an identifier byte and drops out_valid_o.
`default_nettype none

module ber_tag_length_header_parser_top import btlhp_pkg::*; #(
  parameter int unsigned MAX_LEN_OCTETS = MaxLenOctetsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [1:0]  status_o,
  output      logic [7:0]  tag_byte_o,
  output      logic [1:0]  tag_class_o,
  output      logic        constructed_o,
  output      logic [4:0]  tag_number_o,
  output      logic [6:0]  tag_extension_o,
  output      logic [1:0]  tag_bytes_o,
  output      logic [31:0] length_value_o,
  output      logic [2:0]  length_bytes_o
);

  localparam int unsigned RemW = $clog2(MAX_LEN_OCTETS + 1);

  parse_state_t    st_q, st_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic            emit;
  result_t         res, res_q;
  logic            out_valid_q;
  logic            in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  btlhp_step #(
    .MAX_LEN_OCTETS (MAX_LEN_OCTETS),
    .RemW           (RemW)
  ) u_step (
    .st_q_i        (st_q),
    .rem_q_i       (rem_q),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .st_d_o        (st_d),
    .rem_d_o       (rem_d),
    .emit_o        (emit),
    .res_o         (res)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase   <= PhIdent;
      st_q.tag     <= '0;
      st_q.ext     <= '0;
      st_q.acc     <= '0;
      st_q.oct_cnt <= '0;
      st_q.tag_cnt <= '0;
      rem_q        <= '0;
    end else if (in_fire) begin
      st_q  <= st_d;
      rem_q <= rem_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (in_fire && emit) out_valid_q <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) res_q <= res;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign tag_byte_o      = res_q.tag;
  assign tag_class_o     = res_q.tag[7:6];
  assign constructed_o   = res_q.tag[5];
  assign tag_number_o    = res_q.tag[4:0];
  assign tag_extension_o = res_q.ext;
  assign tag_bytes_o     = res_q.tag_cnt;
  assign length_value_o  = res_q.len;
  assign length_bytes_o  = res_q.oct_cnt;

endmodule

`default_nettype wire

>>> sv/btlhp_checker.sv
// port-level checks of the ber tag-length header parser, with its bind
// depends on btlhp_pkg and the defines header
`default_nettype none
`include "ber_tag_length_header_parser_top_defines.svh"

module btlhp_checker import btlhp_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [7:0]  tag_byte_o,
  input wire logic [4:0]  tag_number_o,
  input wire logic [6:0]  tag_extension_o,
  input wire logic [1:0]  tag_bytes_o,
  input wire logic [31:0] length_value_o,
  input wire logic [2:0]  length_bytes_o
);

  // a stalled result holds
  `BTLHP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(length_value_o) && $stable(tag_byte_o), "result changed while stalled")

  // no result during reset
  `BTLHP_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

  // failed headers carry no length
  `BTLHP_ASSERT(a_err_len, clk_i, rst_ni, out_valid_o && status_o != StOk |-> length_value_o == 32'd0, "length set on failed header")

  // extension only follows tag number 31
  `BTLHP_ASSERT(a_ext, clk_i, rst_ni, out_valid_o && tag_number_o != TagNumExt |-> tag_extension_o == 7'd0 && tag_bytes_o == 2'd1, "extension without extended tag number")

  // a full header consumed at least one length byte
  `BTLHP_ASSERT(a_ok_len_bytes, clk_i, rst_ni, out_valid_o && status_o == StOk |-> length_bytes_o != 3'd0 && (tag_bytes_o == 2'd1 || tag_bytes_o == 2'd2), "ok header with bad byte counts")

endmodule

bind ber_tag_length_header_parser_top btlhp_checker u_btlhp_checker (.*);

`default_nettype wire

>>> test/ber_tag_length_header_parser_top_checker.sv
// checker for the ber tag-length header parser: tracks the header parse per
// accepted byte and compares each delivered result with the oldest one due
// depends on btlhp_pkg
`default_nettype none

module ber_tag_length_header_parser_top_checker import btlhp_pkg::*; #(
  parameter int unsigned MAX_LEN_OCTETS = MaxLenOctetsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_data_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [7:0]  tag_byte_i,
  input  wire logic [1:0]  tag_class_i,
  input  wire logic        constructed_i,
  input  wire logic [4:0]  tag_number_i,
  input  wire logic [6:0]  tag_extension_i,
  input  wire logic [1:0]  tag_bytes_i,
  input  wire logic [31:0] length_value_i,
  input  wire logic [2:0]  length_bytes_i,
  output int               fail_count_o,
  output int               pending_o
);

  // tracked parse state
  phase_e      hdr_phase;
  logic [7:0]  hdr_tag;
  logic [6:0]  hdr_ext;
  logic [31:0] len_acc;
  logic [3:0]  octets_left;
  logic [2:0]  len_octets;
  logic [1:0]  tag_octets;

  // headers whose result has not been delivered yet
  result_t headers_due[$];
  int      mismatches = 0;

  // close the current header with a status and go back to the identifier
  task automatic close_header(input status_e st, input logic [31:0] len);
    result_t r;
    r.status  = st;
    r.tag     = hdr_tag;
    r.ext     = hdr_ext;
    r.tag_cnt = tag_octets;
    r.len     = (st == StOk) ? len : 32'd0;
    r.oct_cnt = len_octets;
    headers_due.push_back(r);
    hdr_phase = PhIdent;
  endtask

  // advance the header parse by one byte
  task automatic parse_byte(input logic [7:0] b, input logic eod);
    logic [6:0] cnt;
    bit         closed;
    closed = 1'b0;
    cnt    = b[6:0];
    case (hdr_phase)
      PhIdent: begin
        hdr_tag     = b;
        hdr_ext     = '0;
        tag_octets  = 2'd1;
        len_octets  = '0;
        len_acc     = '0;
        octets_left = '0;
        hdr_phase   = (b[4:0] == TagNumExt) ? PhExt : PhLenFirst;
      end
      PhExt: begin
        hdr_ext    = b[6:0];
        tag_octets = 2'd2;
        hdr_phase  = PhLenFirst;
      end
      PhLenFirst: begin
        len_octets = 3'd1;
        closed     = 1'b1;
        if (!b[7]) begin
          close_header(StOk, {24'd0, b});
        end else if (cnt == 7'd0) begin
          close_header(StIndef, 32'd0);
        end else if (cnt > MAX_LEN_OCTETS) begin
          close_header(StTooMany, 32'd0);
        end else begin
          len_acc     = '0;
          octets_left = cnt[3:0];
          hdr_phase   = PhLenMore;
          closed      = 1'b0;
        end
      end
      default: begin
        len_acc    = {len_acc[23:0], b};
        len_octets = len_octets + 3'd1;
        if (octets_left > 0) octets_left = octets_left - 4'd1;
        if (octets_left == 0) begin
          close_header(StOk, len_acc);
          closed = 1'b1;
        end
      end
    endcase
    // end of data inside a header that did not close
    if (!closed && eod) close_header(StTrunc, 32'd0);
  endtask

  // compare one delivered result with the oldest header due
  task automatic check_result();
    result_t exp_r;
    if (headers_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with no header due: status %0d tag %02h len %0d",
                 $realtime, status_i, tag_byte_i, length_value_i);
    end else begin
      exp_r = headers_due.pop_front();
      if (status_i != exp_r.status || tag_byte_i != exp_r.tag ||
          tag_class_i != exp_r.tag[7:6] || constructed_i != exp_r.tag[5] ||
          tag_number_i != exp_r.tag[4:0] || tag_extension_i != exp_r.ext ||
          tag_bytes_i != exp_r.tag_cnt || length_value_i != exp_r.len ||
          length_bytes_i != exp_r.oct_cnt) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: header mismatch, expected status %0d tag %02h ext %02h",
                   $realtime, exp_r.status, exp_r.tag, exp_r.ext);
          $display("  tag_bytes %0d length %0d length_bytes %0d",
                   exp_r.tag_cnt, exp_r.len, exp_r.oct_cnt);
          $display("  got status %0d tag %02h class %0d cons %0d num %0d ext %02h",
                   status_i, tag_byte_i, tag_class_i, constructed_i,
                   tag_number_i, tag_extension_i);
          $display("  tag_bytes %0d length %0d length_bytes %0d",
                   tag_bytes_i, length_value_i, length_bytes_i);
        end
      end
    end
  endtask

  // input item first so a same-edge result still finds its header queued
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_phase   = PhIdent;
      hdr_tag     = '0;
      hdr_ext     = '0;
      len_acc     = '0;
      octets_left = '0;
      len_octets  = '0;
      tag_octets  = '0;
      headers_due.delete();
    end else begin
      if (in_valid_i && in_ready_i) parse_byte(data_byte_i, end_of_data_i);
      if (out_valid_i && out_ready_i) check_result();
    end
    pending_o    = headers_due.size();
    fail_count_o = mismatches;
  end

endmodule

`default_nettype wire

>>> test/ber_tag_length_header_parser_top_tb.sv
// testbench top for the ber tag-length header parser: drives byte streams of
// directed and random headers, idles both channels and gives the verdict
// depends on btlhp_pkg, ber_tag_length_header_parser_top and its checker
`default_nettype none

module ber_tag_length_header_parser_top_tb import btlhp_pkg::*;;

  localparam int unsigned StreamBytes = 1450;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        end_of_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [7:0]  tag_byte;
  logic [1:0]  tag_class;
  logic        constructed;
  logic [4:0]  tag_number;
  logic [6:0]  tag_extension;
  logic [1:0]  tag_bytes;
  logic [31:0] length_value;
  logic [2:0]  length_bytes;

  int          fail_count;
  int          pending;
  int unsigned bytes_sent;
  int unsigned idle_run = 0;
  bit          steady;

  ber_tag_length_header_parser_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .end_of_data_i  (end_of_data),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .tag_byte_o     (tag_byte),
    .tag_class_o    (tag_class),
    .constructed_o  (constructed),
    .tag_number_o   (tag_number),
    .tag_extension_o(tag_extension),
    .tag_bytes_o    (tag_bytes),
    .length_value_o (length_value),
    .length_bytes_o (length_bytes)
  );

  ber_tag_length_header_parser_top_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .data_byte_i    (data_byte),
    .end_of_data_i  (end_of_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .tag_byte_i     (tag_byte),
    .tag_class_i    (tag_class),
    .constructed_i  (constructed),
    .tag_number_i   (tag_number),
    .tag_extension_i(tag_extension),
    .tag_bytes_i    (tag_bytes),
    .length_value_i (length_value),
    .length_bytes_i (length_bytes),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle length: mostly short, a few long, none during steady stretches
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // offer one byte after a random gap; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eod);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_data <= eod;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // one header with random content, sometimes cut short by end of data
  task automatic send_header();
    logic [7:0]  hdr[$];
    logic [7:0]  id_byte;
    int unsigned form;
    int unsigned n;
    int unsigned cut;
    logic        eod;
    id_byte = 8'($urandom);
    if ($urandom_range(3) == 0) id_byte[4:0] = TagNumExt;
    hdr.push_back(id_byte);
    if (id_byte[4:0] == TagNumExt) hdr.push_back(8'($urandom));
    form = $urandom_range(9);
    if (form < 5) begin
      hdr.push_back({1'b0, 7'($urandom)});
    end else if (form < 8) begin
      n = $urandom_range(1, MaxLenOctetsDef);
      hdr.push_back({1'b1, 7'(n)});
      repeat (n) hdr.push_back(8'($urandom));
    end else if (form == 8) begin
      hdr.push_back(8'h80);
    end else begin
      hdr.push_back({1'b1, 7'($urandom_range(MaxLenOctetsDef + 1, 127))});
    end
    cut = hdr.size();
    if ($urandom_range(9) == 0) cut = $urandom_range(1, hdr.size());
    for (int i = 0; i < cut; i++) begin
      eod = (i == cut - 1) && (cut < hdr.size() || $urandom_range(7) == 0);
      send_byte(hdr[i], eod);
    end
  endtask

  // random bytes, the last with end of data so the next header starts aligned
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
  endtask

  // result side: random stalls
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      int unsigned stall;
      stall = idle_cycles();
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      idle_run++;
      if (idle_run >= StallLimit) begin
        $display("ber_tag_length_header_parser_top regression: fail");
        $finish;
      end
    end else begin
      idle_run = 0;
    end
  end

  // stimulus and verdict
  initial begin
    in_valid    = 1'b0;
    data_byte   = '0;
    end_of_data = 1'b0;
    steady      = 1'b0;
    bytes_sent  = 0;
    rst_n       = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // universal primitive, tag 0, length 0
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // private constructed, extended tag, largest short length
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    // indefinite length after an extension byte
    send_byte(8'h1F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    // four length octets, all ones
    send_byte(8'h30, 1'b0);
    send_byte(8'h84, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    // too many length octets, largest and smallest count
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h85, 1'b0);
    // end of data on the byte that finishes a header
    send_byte(8'h84, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h00, 1'b1);
    // end of data on identifier, extension, first and later length bytes
    send_byte(8'h1F, 1'b1);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h40, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'h40, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    // indefinite form reported even with end of data
    send_byte(8'hA1, 1'b0);
    send_byte(8'h80, 1'b1);

    // random headers with some noise and steady stretches
    while (bytes_sent < StreamBytes) begin
      if ($urandom_range(19) == 0) steady = !steady;
      if ($urandom_range(9) == 0) send_noise();
      else send_header();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("ber_tag_length_header_parser_top regression: pass");
    end else begin
      $display("ber_tag_length_header_parser_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
